### design/gpto_pkg.sv
// ----------------------------------------------------------------------------
// gpto_pkg
// Types and constants shared by the graph prune / topological order block.
// ----------------------------------------------------------------------------
`default_nettype none

package gpto_pkg;

    localparam int NODE_W  = 4;
    localparam int SLOTS   = 16;   // node indices that the item fields can name
    localparam int SLOT_CW = 5;    // counts of 0..SLOTS
    localparam int CFG_W   = 5;

    typedef enum logic [1:0] {
        KIND_ROOT  = 2'd0,
        KIND_IN    = 2'd1,
        KIND_OUT   = 2'd2,
        KIND_START = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_NODE     = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_CYCLE    = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEED,
        S_POP,
        S_POP_WAIT,
        S_SCAN,
        S_SCAN_WAIT,
        S_FIND,
        S_OUT_RD,
        S_OUT_WAIT,
        S_TAKE,
        S_EMIT,
        S_ERR
    } t_state;

    typedef struct packed {
        logic    in_ready;
        logic    load;
        logic    begin_run;
        logic    seed;
        logic    pop;
        logic    keep;
        logic    scan_chk;
        logic    select_node;
        logic    dec;
        logic    take;
        logic    emit_node;
        logic    emit_err;
        t_status err_code;
        logic    clear;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic in_start;
        logic overflow;
        logic seed_done;
        logic stack_empty;
        logic kept_none;
        logic pop_fresh;
        logic pop_has_edges;
        logic list_done;
        logic all_done;
        logic zero_found;
        logic sel_has_edges;
        logic emit_last;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

### design/gpto_intf.sv
// ----------------------------------------------------------------------------
// gpto_intf
// Valid/ready channels for graph items and for ordered results.
// ----------------------------------------------------------------------------
`default_nettype none

interface gpto_in_if;
    import gpto_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] other;
    modport source (output valid, kind, node, other, input ready);
    modport sink   (input valid, kind, node, other, output ready);
endinterface

interface gpto_out_if;
    import gpto_pkg::*;
    logic              valid;
    logic              ready;
    logic [NODE_W-1:0] exec_node;
    logic [1:0]        status;
    logic              last;
    modport source (output valid, exec_node, status, last, input ready);
    modport sink   (input valid, exec_node, status, last, output ready);
endinterface

`default_nettype wire

### design/gpto_ram.sv
// ----------------------------------------------------------------------------
// gpto_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gpto_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### design/gpto_ctrl.sv
// ----------------------------------------------------------------------------
// gpto_ctrl
// Sequencer: loading, depth-first walk, Kahn rounds and result emission.
// ----------------------------------------------------------------------------
`default_nettype none

module gpto_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire gpto_pkg::t_sts i_sts,
    output gpto_pkg::t_cmd     o_cmd
);
    import gpto_pkg::*;

    t_state  r_state, n_state;
    t_status r_err, n_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_err   <= ST_EMPTY;
        end else begin
            r_state <= n_state;
            r_err   <= n_err;
        end
    end

    always_comb begin
        n_state = r_state;
        n_err   = r_err;
        o_cmd   = '0;
        o_cmd.err_code = r_err;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_valid) begin
                    if (i_sts.in_start) begin
                        o_cmd.begin_run = 1'b1;
                        if (i_sts.overflow) begin
                            n_err   = ST_OVERFLOW;
                            n_state = S_ERR;
                        end else begin
                            n_state = S_SEED;
                        end
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            S_SEED: begin
                o_cmd.seed = 1'b1;
                if (i_sts.seed_done) begin
                    n_state = S_POP;
                end
            end
            S_POP: begin
                if (!i_sts.stack_empty) begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_POP_WAIT;
                end else if (i_sts.kept_none) begin
                    n_err   = ST_EMPTY;
                    n_state = S_ERR;
                end else begin
                    n_state = S_FIND;
                end
            end
            S_POP_WAIT: begin
                n_state = S_POP;
                if (i_sts.pop_fresh) begin
                    o_cmd.keep = 1'b1;
                    if (i_sts.pop_has_edges) begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                n_state = S_SCAN_WAIT;
            end
            S_SCAN_WAIT: begin
                o_cmd.scan_chk = 1'b1;
                n_state = i_sts.list_done ? S_POP : S_SCAN;
            end
            S_FIND: begin
                if (i_sts.all_done) begin
                    n_state = S_EMIT;
                end else if (!i_sts.zero_found) begin
                    n_err   = ST_CYCLE;
                    n_state = S_ERR;
                end else begin
                    o_cmd.select_node = 1'b1;
                    n_state = i_sts.sel_has_edges ? S_OUT_RD : S_TAKE;
                end
            end
            S_OUT_RD: begin
                n_state = S_OUT_WAIT;
            end
            S_OUT_WAIT: begin
                o_cmd.dec = 1'b1;
                n_state = i_sts.list_done ? S_TAKE : S_OUT_RD;
            end
            S_TAKE: begin
                o_cmd.take = 1'b1;
                n_state    = S_FIND;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_node = 1'b1;
                    if (i_sts.emit_last) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_IDLE;
                    end
                end
            end
            S_ERR: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_err = 1'b1;
                    o_cmd.clear    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

### design/gpto_dp.sv
// ----------------------------------------------------------------------------
// gpto_dp
// Graph store, walk stack, kept list and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gpto_dp #(
    parameter int MAX_NODES = 16,
    parameter int MAX_LIST  = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [gpto_pkg::CFG_W-1:0]  i_cfg_data,
    input  wire logic                        i_in_valid,
    input  wire logic [1:0]                  i_kind,
    input  wire logic [gpto_pkg::NODE_W-1:0] i_node,
    input  wire logic [gpto_pkg::NODE_W-1:0] i_other,
    input  wire logic                        i_out_ready,
    output logic                             o_out_valid,
    output logic      [gpto_pkg::NODE_W-1:0] o_exec_node,
    output logic      [1:0]                  o_status,
    output logic                             o_last,
    input  wire gpto_pkg::t_cmd              i_cmd,
    output gpto_pkg::t_sts                   o_sts
);
    import gpto_pkg::*;

    localparam int CAP       = (MAX_NODES > 31) ? 31 : MAX_NODES;
    localparam int LIST_W    = (MAX_LIST > 1) ? $clog2(MAX_LIST) : 1;
    localparam int LEN_W     = $clog2(MAX_LIST + 1);
    localparam int STORE_D   = SLOTS * MAX_LIST;
    localparam int STORE_AW  = $clog2(STORE_D);
    localparam int STK_D     = SLOTS + SLOTS * MAX_LIST;
    localparam int STK_AW    = $clog2(STK_D);
    localparam int STK_PW    = $clog2(STK_D + 1);

    // configuration and active count
    logic [CFG_W-1:0] r_node_count;
    logic [CFG_W-1:0] act;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= CFG_W'(16);
        end else if (i_cfg_we) begin
            r_node_count <= i_cfg_data;
        end
    end

    assign act = (r_node_count > CFG_W'(CAP)) ? CFG_W'(CAP) : r_node_count;

    // graph store
    logic [SLOTS-1:0] r_root;
    logic [LEN_W-1:0] r_in_len  [SLOTS];
    logic [LEN_W-1:0] r_out_len [SLOTS];
    logic             r_overflow;
    logic [SLOTS-1:0] r_visited;

    logic node_ok, other_ok, load_in, load_out, in_full, out_full;
    assign node_ok  = {1'b0, i_node} < act;
    assign other_ok = {1'b0, i_other} < act;
    assign in_full  = r_in_len[i_node] == LEN_W'(MAX_LIST);
    assign out_full = r_out_len[i_node] == LEN_W'(MAX_LIST);
    assign load_in  = i_cmd.load && i_kind == KIND_IN && node_ok && other_ok;
    assign load_out = i_cmd.load && i_kind == KIND_OUT && node_ok && other_ok;

    // walk registers
    logic [NODE_W-1:0]  r_cur;
    logic [LEN_W-1:0]   r_cur_len;
    logic [LEN_W-1:0]   r_j;
    logic [NODE_W-1:0]  r_idx;
    logic [STK_PW-1:0]  r_sp;
    logic [SLOT_CW-1:0] r_kept;
    logic [SLOT_CW-1:0] r_emitted;
    logic [NODE_W-1:0]  r_e;
    logic [NODE_W-1:0]  r_pos;
    logic [NODE_W-1:0]  r_kord   [SLOTS];
    logic [LEN_W-1:0]   r_kcnt   [SLOTS];
    logic [SLOTS-1:0]   r_removed;
    logic [NODE_W-1:0]  r_order  [SLOTS];

    // memories
    logic [NODE_W-1:0]   in_rdata, out_rdata, stk_rdata;
    logic [STORE_AW-1:0] st_waddr, st_raddr;
    logic                stk_we;
    logic [NODE_W-1:0]   stk_wdata;
    logic [STK_AW-1:0]   stk_raddr;

    assign st_waddr = STORE_AW'(i_node) * STORE_AW'(MAX_LIST)
                    + STORE_AW'(load_in ? r_in_len[i_node] : r_out_len[i_node]);
    assign st_raddr = STORE_AW'(r_cur) * STORE_AW'(MAX_LIST)
                    + STORE_AW'(r_j[LIST_W-1:0]);

    gpto_ram #(.WIDTH(NODE_W), .DEPTH(STORE_D)) u_in_ram (
        .i_clk   (i_clk),
        .i_we    (load_in && !in_full),
        .i_waddr (st_waddr),
        .i_wdata (i_other),
        .i_raddr (st_raddr),
        .o_rdata (in_rdata)
    );

    gpto_ram #(.WIDTH(NODE_W), .DEPTH(STORE_D)) u_out_ram (
        .i_clk   (i_clk),
        .i_we    (load_out && !out_full),
        .i_waddr (st_waddr),
        .i_wdata (i_other),
        .i_raddr (st_raddr),
        .o_rdata (out_rdata)
    );

    logic seed_push, scan_push;
    assign seed_push = i_cmd.seed && r_root[r_idx] && ({1'b0, r_idx} < act);
    assign scan_push = i_cmd.scan_chk && ({1'b0, in_rdata} < act) && !r_visited[in_rdata];
    assign stk_we    = seed_push || scan_push;
    assign stk_wdata = seed_push ? r_idx : in_rdata;
    assign stk_raddr = STK_AW'(r_sp - STK_PW'(1));

    gpto_ram #(.WIDTH(NODE_W), .DEPTH(STK_D)) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (r_sp[STK_AW-1:0]),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    // first live kept entry at zero
    logic              zero_found;
    logic [NODE_W-1:0] zero_pos;
    logic [SLOTS-1:0]  live;

    always_comb begin
        zero_found = 1'b0;
        zero_pos   = '0;
        for (int k = 0; k < SLOTS; k++) begin
            live[k] = (SLOT_CW'(k) < r_kept) && !r_removed[k];
            if (!zero_found && live[k] && r_kcnt[k] == '0) begin
                zero_found = 1'b1;
                zero_pos   = NODE_W'(k);
            end
        end
    end

    logic out_free;
    assign out_free = !o_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root     <= '0;
            r_overflow <= 1'b0;
            r_visited  <= '0;
            for (int k = 0; k < SLOTS; k++) begin
                r_in_len[k]  <= '0;
                r_out_len[k] <= '0;
            end
        end else begin
            if (i_cmd.load && node_ok && i_kind == KIND_ROOT) begin
                r_root[i_node] <= 1'b1;
            end
            if (load_in) begin
                if (in_full) r_overflow <= 1'b1;
                else         r_in_len[i_node] <= r_in_len[i_node] + LEN_W'(1);
            end
            if (load_out) begin
                if (out_full) r_overflow <= 1'b1;
                else          r_out_len[i_node] <= r_out_len[i_node] + LEN_W'(1);
            end
            if (i_cmd.begin_run) begin
                r_visited <= '0;
            end
            if (i_cmd.keep) begin
                r_visited[stk_rdata] <= 1'b1;
            end
            if (i_cmd.clear) begin
                r_root     <= '0;
                r_overflow <= 1'b0;
                r_visited  <= '0;
                for (int k = 0; k < SLOTS; k++) begin
                    r_in_len[k]  <= '0;
                    r_out_len[k] <= '0;
                end
            end
        end
    end

    // walk and Kahn control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp        <= '0;
            r_kept      <= '0;
            r_emitted   <= '0;
            r_idx       <= '0;
            r_e         <= '0;
            r_removed   <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cmd.begin_run) begin
                r_sp      <= '0;
                r_kept    <= '0;
                r_emitted <= '0;
                r_idx     <= '0;
                r_e       <= '0;
                r_removed <= '0;
            end
            if (i_cmd.seed) begin
                r_idx <= r_idx + NODE_W'(1);
            end
            if (stk_we) begin
                r_sp <= r_sp + STK_PW'(1);
            end else if (i_cmd.pop) begin
                r_sp <= r_sp - STK_PW'(1);
            end
            if (i_cmd.keep) begin
                r_kept <= r_kept + SLOT_CW'(1);
            end
            if (i_cmd.take) begin
                r_removed[r_pos] <= 1'b1;
                r_emitted        <= r_emitted + SLOT_CW'(1);
            end
            if (i_cmd.emit_node) begin
                r_e <= r_e + NODE_W'(1);
            end
            if (i_cmd.emit_node || i_cmd.emit_err) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.keep) begin
            r_kord[r_kept[NODE_W-1:0]] <= stk_rdata;
            r_kcnt[r_kept[NODE_W-1:0]] <= r_in_len[stk_rdata];
            r_cur     <= stk_rdata;
            r_cur_len <= r_in_len[stk_rdata];
            r_j       <= '0;
        end
        if (i_cmd.select_node) begin
            r_pos     <= zero_pos;
            r_cur     <= r_kord[zero_pos];
            r_cur_len <= r_out_len[r_kord[zero_pos]];
            r_j       <= '0;
        end
        if (i_cmd.scan_chk || i_cmd.dec) begin
            r_j <= r_j + LEN_W'(1);
        end
        if (i_cmd.dec) begin
            // each node sits in the kept list once, so the match is unique
            for (int k = 0; k < SLOTS; k++) begin
                if (live[k] && r_kord[k] == out_rdata && r_kcnt[k] != '0) begin
                    r_kcnt[k] <= r_kcnt[k] - LEN_W'(1);
                end
            end
        end
        if (i_cmd.take) begin
            r_order[r_emitted[NODE_W-1:0]] <= r_cur;
        end
        if (i_cmd.emit_node) begin
            o_exec_node <= r_order[r_e];
            o_status    <= ST_NODE;
            o_last      <= o_sts.emit_last;
        end else if (i_cmd.emit_err) begin
            o_exec_node <= '0;
            o_status    <= i_cmd.err_code;
            o_last      <= 1'b1;
        end
    end

    always_comb begin
        o_sts               = '0;
        o_sts.in_valid      = i_in_valid;
        o_sts.in_start      = i_kind == KIND_START;
        o_sts.overflow      = r_overflow;
        o_sts.seed_done     = r_idx == NODE_W'(SLOTS - 1);
        o_sts.stack_empty   = r_sp == '0;
        o_sts.kept_none     = r_kept == '0;
        o_sts.pop_fresh     = ({1'b0, stk_rdata} < act) && !r_visited[stk_rdata];
        o_sts.pop_has_edges = r_in_len[stk_rdata] != '0;
        o_sts.list_done     = (r_j + LEN_W'(1)) == r_cur_len;
        o_sts.all_done      = r_emitted == r_kept;
        o_sts.zero_found    = zero_found;
        o_sts.sel_has_edges = r_out_len[r_kord[zero_pos]] != '0;
        o_sts.emit_last     = ({1'b0, r_e} + SLOT_CW'(1)) == r_emitted;
        o_sts.out_free      = out_free;
    end

endmodule

`default_nettype wire

### design/graph_prune_topological_order.sv
// ----------------------------------------------------------------------------
// graph_prune_topological_order
// Prunes a loaded dependency graph to the nodes reachable from its roots and
// emits them in topological order.
//
//   channel  | dir | handshake     | payload
//   i_in     | in  | valid/ready   | kind, node, other
//   o_out    | out | valid/ready   | exec_node, status, last
//   cfg      | in  | i_cfg_we      | i_cfg_data = node_count
//
// Root marks and edges are accepted back to back while the sequencer is idle.
// A start item seeds the walk stack from every root mark, pops it until it is
// empty and scans the in-edges of each fresh node it keeps, then runs Kahn
// rounds, each picking a node with no pending in-edges and reading its
// out-edges, and then emits the results; the edge RAM reads are registered.
// Input ready is low from a start until its last result enters the output
// register; a stalled output holds the sequencer in its emit or error step.
// Reset is synchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module graph_prune_topological_order #(
    parameter int MAX_NODES = 16,
    parameter int MAX_LIST  = 32
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [gpto_pkg::CFG_W-1:0] i_cfg_data,
    gpto_in_if.sink                         i_in,
    gpto_out_if.source                      o_out
);
    import gpto_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign i_in.ready = cmd.in_ready;

    gpto_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    gpto_dp #(
        .MAX_NODES (MAX_NODES),
        .MAX_LIST  (MAX_LIST)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in.valid),
        .i_kind       (i_in.kind),
        .i_node       (i_in.node),
        .i_other      (i_in.other),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_exec_node  (o_out.exec_node),
        .o_status     (o_out.status),
        .o_last       (o_out.last),
        .i_cmd        (cmd),
        .o_sts        (sts)
    );

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for graph_prune_topological_order. Loads graphs as root marks and
// edges, starts each one, and checks every emitted node or error status
// against an internal model of the prune walk and Kahn ordering. Graphs are
// mostly random DAGs, with cycles, overflows and noise items mixed in, under
// several node counts and random stalls on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import gpto_pkg::*;

    localparam int LIST_MAX   = 32;
    localparam int IDLE_LIMIT = 20000;
    localparam int RAND_ITEMS = 290;

    typedef struct {
        logic [3:0] idx;
        t_status    st;
        logic       last;
    } t_result;

    typedef struct {
        t_kind   kind;
        int      node;
        int      other;
        bit      typed;
        t_status st;
        int      idx;
    } t_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [4:0] i_cfg_data;

    gpto_in_if  in_ch ();
    gpto_out_if out_ch ();

    graph_prune_topological_order dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    // model state
    int         node_limit;
    bit         root_mark [16];
    logic [3:0] in_list   [16][LIST_MAX];
    int         in_len    [16];
    logic [3:0] out_list  [16][LIST_MAX];
    int         out_len   [16];
    bit         list_full;

    t_result expected_order[$];
    t_result fresh[$];

    int  failures;
    int  mismatches;
    int  idle_cycles;
    int  items_sent;
    int  rand_items;
    int  results_seen;
    int  starts_sent;
    int  stall_left;
    bit  tx_calm;
    bit  rx_calm;
    t_row directed_rows[$];

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic int active_nodes();
        return node_limit < 16 ? node_limit : 16;
    endfunction

    function automatic void clear_graph();
        for (int i = 0; i < 16; i++) begin
            root_mark[i] = 0;
            in_len[i]    = 0;
            out_len[i]   = 0;
        end
        list_full = 0;
    endfunction

    // prune walk from the roots, then Kahn order over the kept nodes
    function automatic void order_graph();
        int stack[$];
        int kept_n[$];
        int kept_c[$];
        bit seen[16];
        int cnt;
        int n;
        int o;
        int pos;
        fresh.delete();
        cnt = active_nodes();
        if (list_full) begin
            fresh.insert(fresh.size(), '{idx: 4'd0, st: ST_OVERFLOW, last: 1'b1});
            return;
        end
        for (int i = 0; i < 16; i++) seen[i] = 0;
        for (int i = 0; i < cnt; i++)
            if (root_mark[i]) stack.insert(stack.size(), i);
        while (stack.size() > 0) begin
            n = stack[$];
            stack.delete(stack.size() - 1);
            if (n >= cnt || seen[n]) continue;
            seen[n] = 1;
            kept_n.insert(kept_n.size(), n);
            kept_c.insert(kept_c.size(), in_len[n]);
            for (int j = 0; j < in_len[n]; j++) begin
                o = in_list[n][j];
                if (o < cnt && !seen[o]) stack.insert(stack.size(), o);
            end
        end
        if (kept_n.size() == 0) begin
            fresh.insert(fresh.size(), '{idx: 4'd0, st: ST_EMPTY, last: 1'b1});
            return;
        end
        while (kept_n.size() > 0) begin
            pos = -1;
            for (int i = 0; i < kept_n.size(); i++)
                if (kept_c[i] == 0) begin
                    pos = i;
                    break;
                end
            if (pos < 0) begin
                fresh.delete();
                fresh.insert(fresh.size(), '{idx: 4'd0, st: ST_CYCLE, last: 1'b1});
                return;
            end
            n = kept_n[pos];
            for (int j = 0; j < out_len[n]; j++)
                for (int i = 0; i < kept_n.size(); i++)
                    if (kept_n[i] == out_list[n][j]) begin
                        if (kept_c[i] > 0) kept_c[i]--;
                        break;
                    end
            fresh.insert(fresh.size(), '{idx: 4'(n), st: ST_NODE, last: 1'b0});
            kept_n.delete(pos);
            kept_c.delete(pos);
        end
        fresh[fresh.size()-1].last = 1'b1;
    endfunction

    // applies one accepted transaction to the model; returns 1 on a start
    function automatic bit apply_item(t_kind kind, int n, int o);
        int cnt;
        cnt = active_nodes();
        if (kind == KIND_START) begin
            order_graph();
            clear_graph();
            return 1;
        end
        if (n >= cnt) return 0;
        if (kind == KIND_ROOT) begin
            root_mark[n] = 1;
            return 0;
        end
        if (o >= cnt) return 0;
        if (kind == KIND_IN) begin
            if (in_len[n] >= LIST_MAX) list_full = 1;
            else begin
                in_list[n][in_len[n]] = 4'(o);
                in_len[n]++;
            end
        end else begin
            if (out_len[n] >= LIST_MAX) list_full = 1;
            else begin
                out_list[n][out_len[n]] = 4'(o);
                out_len[n]++;
            end
        end
        return 0;
    endfunction

    function automatic int pick_gap(bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send(t_kind kind, int n, int o, bit typed = 0,
                        t_result fixed = '{0, ST_NODE, 0});
        int gap;
        gap = pick_gap(tx_calm);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.kind  <= kind;
        in_ch.node  <= 4'(n);
        in_ch.other <= 4'(o);
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_sent++;
        if (apply_item(kind, n, o)) begin
            starts_sent++;
            if (typed) expected_order.insert(expected_order.size(), fixed);
            else foreach (fresh[i]) expected_order.insert(expected_order.size(), fresh[i]);
        end
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_order.size() > 0) @(posedge i_clk);
    endtask

    task automatic set_nodes(int v);
        drain();
        repeat (40) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= 5'(v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        node_limit = v;
    endtask

    // one random graph followed by its start transaction
    task automatic random_graph();
        int perm[16];
        int span;
        int shape;
        int m;
        int a;
        int b;
        int t;
        int v;
        span = active_nodes();
        if (span < 2 || $urandom_range(0, 9) == 0) span = 16;
        for (int i = 0; i < 16; i++) perm[i] = i;
        for (int i = 15; i > 0; i--) begin
            t = $urandom_range(0, i);
            v = perm[i];
            perm[i] = perm[t];
            perm[t] = v;
        end
        shape = $urandom_range(0, 99);
        if (shape < 8) begin
            // overflow one edge list of either direction
            v = $urandom_range(0, span - 1);
            t = $urandom_range(0, 1) ? KIND_IN : KIND_OUT;
            send(KIND_ROOT, v, 0);
            for (int i = 0; i <= LIST_MAX; i++)
                send(t_kind'(t), v, $urandom_range(0, span - 1));
            rand_items += LIST_MAX + 2;
        end else if (shape < 20) begin
            m = $urandom_range(1, 10);
            for (int i = 0; i < m; i++)
                send(t_kind'($urandom_range(0, 2)), $urandom_range(0, 15),
                     $urandom_range(0, 15));
            rand_items += m;
        end else begin
            m = $urandom_range(0, 8);
            for (int i = 0; i < m; i++) begin
                a = $urandom_range(0, span - 1);
                b = $urandom_range(0, span - 1);
                if (a > b) begin
                    t = a;
                    a = b;
                    b = t;
                end
                if (a == b) continue;
                send(KIND_IN, perm[b], perm[a]);
                if ($urandom_range(0, 5) != 0) send(KIND_OUT, perm[a], perm[b]);
                rand_items += 2;
            end
            if (shape < 35) begin
                // back edge from the last node to the first, which can close a loop
                send(KIND_IN, perm[0], perm[span - 1]);
                send(KIND_OUT, perm[span - 1], perm[0]);
                rand_items += 2;
            end
            m = $urandom_range(1, 3);
            for (int i = 0; i < m; i++)
                send(KIND_ROOT, perm[$urandom_range(span / 2, span - 1)],
                     $urandom_range(0, 15));
            rand_items += m;
        end
        send(KIND_START, $urandom_range(0, 15), $urandom_range(0, 15));
        rand_items++;
    endtask

    // result sink with random stalls
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left--;
        end else begin
            out_ch.ready <= 1'b1;
            if (!rx_calm && $urandom_range(0, 3) == 0) stall_left = pick_gap(1'b0);
        end
    end

    // result checker and watchdog
    always @(posedge i_clk) begin
        t_result want;
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
        else idle_cycles++;
        if (out_ch.valid && out_ch.ready) begin
            results_seen++;
            if (expected_order.size() == 0) begin
                failures++;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result idx=%0d status=%0d last=%0d",
                             out_ch.exec_node, out_ch.status, out_ch.last);
            end else begin
                want = expected_order.pop_front();
                if (out_ch.exec_node !== want.idx || out_ch.status !== want.st
                    || out_ch.last !== want.last) begin
                    failures++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp idx=%0d status=%0d last=%0d,",
                                  " got idx=%0d status=%0d last=%0d"},
                                 want.idx, want.st, want.last,
                                 out_ch.exec_node, out_ch.status, out_ch.last);
                end
            end
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int phase_nodes[6];
        int goal;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_data   = 5'd0;
        in_ch.valid  = 1'b0;
        in_ch.kind   = KIND_ROOT;
        in_ch.node   = 4'd0;
        in_ch.other  = 4'd0;
        out_ch.ready = 1'b0;
        failures = 0;
        mismatches = 0;
        idle_cycles = 0;
        items_sent = 0;
        rand_items = 0;
        results_seen = 0;
        starts_sent = 0;
        stall_left = 0;
        tx_calm = 0;
        rx_calm = 0;
        node_limit = 16;
        clear_graph();
        phase_nodes = '{16, 1, 31, 5, 0, 9};

        directed_rows = '{
            '{KIND_START, 0, 0, 1, ST_EMPTY, 0},
            '{KIND_ROOT, 0, 0, 0, ST_NODE, 0},
            '{KIND_START, 0, 0, 1, ST_NODE, 0},
            '{KIND_ROOT, 15, 0, 0, ST_NODE, 0},
            '{KIND_IN, 15, 14, 0, ST_NODE, 0},
            '{KIND_IN, 14, 15, 0, ST_NODE, 0},
            '{KIND_START, 15, 15, 1, ST_CYCLE, 0},
            '{KIND_ROOT, 3, 0, 0, ST_NODE, 0},
            '{KIND_IN, 3, 3, 0, ST_NODE, 0},        // self in-edge
            '{KIND_START, 0, 0, 1, ST_CYCLE, 0},
            '{KIND_ROOT, 2, 0, 0, ST_NODE, 0},
            '{KIND_IN, 2, 1, 0, ST_NODE, 0},
            '{KIND_IN, 1, 0, 0, ST_NODE, 0},
            '{KIND_IN, 2, 0, 0, ST_NODE, 0},
            '{KIND_OUT, 0, 1, 0, ST_NODE, 0},
            '{KIND_OUT, 0, 2, 0, ST_NODE, 0},
            '{KIND_OUT, 1, 2, 0, ST_NODE, 0},
            '{KIND_OUT, 0, 2, 0, ST_NODE, 0},       // duplicate, saturates
            '{KIND_ROOT, 9, 0, 0, ST_NODE, 0},
            '{KIND_START, 0, 0, 0, ST_NODE, 0}
        };

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i])
            send(directed_rows[i].kind, directed_rows[i].node, directed_rows[i].other,
                 directed_rows[i].typed,
                 '{idx: 4'(directed_rows[i].idx), st: directed_rows[i].st, last: 1'b1});
        // hold the sender until the directed results are all out
        drain();

        for (int p = 0; p < 6; p++) begin
            if (p > 0) set_nodes(phase_nodes[p]);
            tx_calm = (p == 2);
            rx_calm = (p == 3);
            goal = (p + 1) * RAND_ITEMS / 6;
            while (rand_items < goal) random_graph();
        end

        drain();
        repeat (100) @(posedge i_clk);
        if (expected_order.size() > 0) begin
            failures++;
            $display("%0d expected results never arrived", expected_order.size());
        end
        $display("Sent %0d transactions (%0d graph starts) over 6 node counts, 0 to 31;",
                 items_sent, starts_sent);
        $display("checked %0d results, %0d mismatches.", results_seen, mismatches);
        if (failures == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
design/gpto_pkg.sv
design/gpto_intf.sv
design/gpto_ram.sv
design/gpto_ctrl.sv
design/gpto_dp.sv
design/graph_prune_topological_order.sv
tb/tb.sv
